// ===== hw/rtl/sfvt_pkg.sv =====
// Shared types and constants for the state flag value table.
package sfvt_pkg;

    localparam int TableDepthDefault = 16;
    localparam int FlagBitsDefault   = 8;
    localparam int ValueBitsDefault  = 32;
    localparam int QueueDepth        = 2;

    typedef enum logic [1:0] {
        CMD_SET   = 2'd0,
        CMD_UNSET = 2'd1,
        CMD_GET   = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_EXACT    = 3'd0,
        ST_FALLBACK = 3'd1,
        ST_DEFAULT  = 3'd2,
        ST_STORED   = 3'd3,
        ST_REMOVED  = 3'd4,
        ST_ABSENT   = 3'd5,
        ST_FULL     = 3'd6
    } status_t;

endpackage

// ===== hw/rtl/sfvt_ram.sv =====
// Generic RAM with one write port, one read port and registered read.
module sfvt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== hw/rtl/sfvt_front.sv =====
// Input side: takes commands and queues them for the engine.
module sfvt_front #(
    parameter int FLAG_BITS  = sfvt_pkg::FlagBitsDefault,
    parameter int VALUE_BITS = sfvt_pkg::ValueBitsDefault
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [1:0]            in_cmd,
    input  logic [FLAG_BITS-1:0]  in_key,
    input  logic [VALUE_BITS-1:0] in_val,
    output logic                  q_valid,
    input  logic                  q_pop,
    output sfvt_pkg::cmd_t        q_cmd,
    output logic [FLAG_BITS-1:0]  q_key,
    output logic [VALUE_BITS-1:0] q_val
);
    import sfvt_pkg::*;

    cmd_t                  cmd_reg [QueueDepth];
    logic [FLAG_BITS-1:0]  key_reg [QueueDepth];
    logic [VALUE_BITS-1:0] val_reg [QueueDepth];
    logic                  wp_reg, rp_reg;
    logic [1:0]            cnt_reg;
    logic                  push;

    assign in_ready = (cnt_reg != 2'(QueueDepth));
    assign push     = in_valid && in_ready;
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_cmd    = cmd_reg[rp_reg];
    assign q_key    = key_reg[rp_reg];
    assign q_val    = val_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            cmd_reg[wp_reg] <= cmd_t'(in_cmd);
            key_reg[wp_reg] <= in_key;
            val_reg[wp_reg] <= in_val;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= ~wp_reg;
            end
            if (q_pop)
            begin
                rp_reg <= ~rp_reg;
            end
            cnt_reg <= cnt_reg + 2'(push) - 2'(q_pop);
        end
    end
endmodule

// ===== hw/rtl/sfvt_engine.sv =====
// Back end: searches, shifts and reads the sorted entries one step a cycle unless output stalls.
module sfvt_engine #(
    parameter int TABLE_DEPTH = sfvt_pkg::TableDepthDefault,
    parameter int FLAG_BITS   = sfvt_pkg::FlagBitsDefault,
    parameter int VALUE_BITS  = sfvt_pkg::ValueBitsDefault
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [31:0]           miss_word,
    input  logic                  q_valid,
    output logic                  q_pop,
    input  sfvt_pkg::cmd_t        q_cmd,
    input  logic [FLAG_BITS-1:0]  q_key,
    input  logic [VALUE_BITS-1:0] q_val,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [2:0]            out_status,
    output logic [31:0]           out_value,
    output logic [4:0]            out_count
);
    import sfvt_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH > 1 ? TABLE_DEPTH : 2);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_SRCH, S_SRCHW, S_INS, S_INSW, S_DEL, S_DELW,
        S_WR, S_SCAN, S_SCANW, S_VRD, S_VRDW, S_DONE
    } state_t;

    state_t                state_reg;
    cmd_t                  cmd_reg;
    logic [FLAG_BITS-1:0]  key_reg;
    logic [VALUE_BITS-1:0] val_reg;
    logic [CW-1:0]         used_reg;
    logic [CW-1:0]         idx_reg;
    logic [2:0]            stat_reg;
    logic [31:0]           rval_reg;
    logic                  ovalid_reg;
    logic [2:0]            ostat_reg;
    logic [31:0]           oval_reg;
    logic [4:0]            ocnt_reg;

    logic                  kwe, vwe;
    logic [AW-1:0]         kwa, vwa, kra, vra;
    logic [FLAG_BITS-1:0]  kwd, krd;
    logic [VALUE_BITS-1:0] vwd, vrd;
    logic [31:0]           vrd32;

    sfvt_ram #(.WIDTH(FLAG_BITS), .DEPTH(TABLE_DEPTH)) u_keys (
        .clk(clk), .we(kwe), .waddr(kwa), .wdata(kwd), .raddr(kra), .rdata(krd));
    sfvt_ram #(.WIDTH(VALUE_BITS), .DEPTH(TABLE_DEPTH)) u_vals (
        .clk(clk), .we(vwe), .waddr(vwa), .wdata(vwd), .raddr(vra), .rdata(vrd));

    always_comb
    begin
        vrd32 = '0;
        vrd32[(VALUE_BITS > 32 ? 32 : VALUE_BITS)-1:0] =
            vrd[(VALUE_BITS > 32 ? 32 : VALUE_BITS)-1:0];
    end

    assign q_pop      = (state_reg == S_IDLE) && q_valid && !ovalid_reg;
    assign out_valid  = ovalid_reg;
    assign out_status = ostat_reg;
    assign out_value  = oval_reg;
    assign out_count  = ocnt_reg;

    // Memory control follows the state; an entry moves by a read in S_INS/S_DEL, then a write.
    always_comb
    begin
        kwe = 1'b0;
        vwe = 1'b0;
        kwa = idx_reg[AW-1:0];
        vwa = idx_reg[AW-1:0];
        kwd = krd;
        vwd = vrd;
        kra = idx_reg[AW-1:0];
        vra = idx_reg[AW-1:0];
        case (state_reg)
            S_INS:
            begin
                kra = AW'(idx_reg - CW'(1));
                vra = AW'(idx_reg - CW'(1));
            end
            S_INSW:
            begin
                kwe = 1'b1;
                vwe = 1'b1;
            end
            S_DEL:
            begin
                kra = AW'(idx_reg + CW'(1));
                vra = AW'(idx_reg + CW'(1));
            end
            S_DELW:
            begin
                kwe = 1'b1;
                vwe = 1'b1;
            end
            S_WR:
            begin
                kwe = 1'b1;
                vwe = 1'b1;
                kwd = key_reg;
                vwd = val_reg;
            end
            S_SCAN:
            begin
                // The scan looks at the entry just below the current index.
                kra = AW'(idx_reg - CW'(1));
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cmd_reg <= q_cmd;
            key_reg <= q_key;
            val_reg <= q_val;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            used_reg   <= '0;
            idx_reg    <= '0;
            stat_reg   <= ST_ABSENT;
            rval_reg   <= '0;
            ovalid_reg <= 1'b0;
            ostat_reg  <= '0;
            oval_reg   <= '0;
            ocnt_reg   <= '0;
        end
        else
        begin
            if (ovalid_reg && out_ready && state_reg != S_DONE)
            begin
                ovalid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (q_pop)
                    begin
                        idx_reg  <= '0;
                        rval_reg <= '0;
                        stat_reg <= ST_ABSENT;
                        state_reg <= (q_cmd == CMD_NONE) ? S_DONE : S_SRCH;
                    end
                end
                S_SRCH:
                begin
                    if (idx_reg >= used_reg)
                    begin
                        // Key is beyond every stored entry.
                        if (cmd_reg == CMD_SET)
                        begin
                            if (used_reg == CW'(TABLE_DEPTH))
                            begin
                                stat_reg  <= ST_FULL;
                                state_reg <= S_DONE;
                            end
                            else
                            begin
                                idx_reg   <= used_reg;
                                state_reg <= S_WR;
                            end
                        end
                        else if (cmd_reg == CMD_GET)
                        begin
                            state_reg <= S_SCAN;
                        end
                        else
                        begin
                            state_reg <= S_DONE;
                        end
                    end
                    else
                    begin
                        state_reg <= S_SRCHW;
                    end
                end
                S_SRCHW:
                begin
                    if (krd < key_reg)
                    begin
                        idx_reg   <= idx_reg + CW'(1);
                        state_reg <= S_SRCH;
                    end
                    else if (krd == key_reg)
                    begin
                        case (cmd_reg)
                            CMD_SET:   state_reg <= S_WR;
                            CMD_UNSET: state_reg <= S_DEL;
                            default:   state_reg <= S_VRD;
                        endcase
                    end
                    else
                    begin
                        case (cmd_reg)
                            CMD_SET:
                            begin
                                if (used_reg == CW'(TABLE_DEPTH))
                                begin
                                    stat_reg  <= ST_FULL;
                                    state_reg <= S_DONE;
                                end
                                else
                                begin
                                    // Shift from the top down to make room.
                                    idx_reg   <= used_reg;
                                    rval_reg  <= 32'(idx_reg);
                                    state_reg <= S_INS;
                                end
                            end
                            CMD_GET:
                            begin
                                idx_reg   <= idx_reg + CW'(1);
                                state_reg <= S_SCAN;
                            end
                            default: state_reg <= S_DONE;
                        endcase
                    end
                end
                S_INS:
                begin
                    if (idx_reg == CW'(rval_reg))
                    begin
                        // Marks the write that follows as a new entry.
                        rval_reg  <= '0;
                        stat_reg  <= ST_STORED;
                        state_reg <= S_WR;
                    end
                    else
                    begin
                        state_reg <= S_INSW;
                    end
                end
                S_INSW:
                begin
                    idx_reg   <= idx_reg - CW'(1);
                    state_reg <= S_INS;
                end
                S_WR:
                begin
                    if (idx_reg == used_reg || stat_reg == ST_STORED)
                    begin
                        used_reg <= used_reg + CW'(1);
                    end
                    stat_reg  <= ST_STORED;
                    state_reg <= S_DONE;
                end
                S_DEL:
                begin
                    if (idx_reg + CW'(1) >= used_reg)
                    begin
                        used_reg  <= used_reg - CW'(1);
                        stat_reg  <= ST_REMOVED;
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        state_reg <= S_DELW;
                    end
                end
                S_DELW:
                begin
                    idx_reg   <= idx_reg + CW'(1);
                    state_reg <= S_DEL;
                end
                S_SCAN:
                begin
                    if (idx_reg == '0)
                    begin
                        stat_reg  <= ST_DEFAULT;
                        rval_reg  <= miss_word;
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg - CW'(1);
                        state_reg <= S_SCANW;
                    end
                end
                S_SCANW:
                begin
                    if (krd == '0 || ((krd & key_reg) != '0 && (krd & ~key_reg) == '0))
                    begin
                        stat_reg  <= ST_FALLBACK;
                        state_reg <= S_VRD;
                    end
                    else
                    begin
                        state_reg <= S_SCAN;
                    end
                end
                S_VRD:
                begin
                    state_reg <= S_VRDW;
                end
                S_VRDW:
                begin
                    if (stat_reg != ST_FALLBACK)
                    begin
                        stat_reg <= ST_EXACT;
                    end
                    rval_reg  <= vrd32;
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (!ovalid_reg || out_ready)
                    begin
                        ovalid_reg <= 1'b1;
                        ostat_reg  <= stat_reg;
                        oval_reg   <= (cmd_reg == CMD_GET) ? rval_reg : '0;
                        ocnt_reg   <= 5'(used_reg);
                        state_reg  <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

// ===== hw/rtl/state_flag_value_table_unit.sv =====
// Top level of the sorted state flag value table.
//  channel | dir | fields (low bit up)
//  s_axis  | in  | tdata: command[1:0], state_flags, write_value
//  m_axis  | out | tdata: status[2:0], read_value, entry_count
//  cfg     | in  | cfg_wdata: word returned by a get that finds neither an exact nor a fallback match
// A command walks the search through the sorted entries one at a time and, on insert
// or removal, shifts entries one at a time in the entry memories; the engine takes
// no new command until the result of the last one has been handed on.
// Reset empties the table at once; stored entries are never cleared.
// A two-beat queue lets input arrive while the engine or output stalls.
module state_flag_value_table_unit #(
    parameter int TABLE_DEPTH = sfvt_pkg::TableDepthDefault,
    parameter int FLAG_BITS   = sfvt_pkg::FlagBitsDefault,
    parameter int VALUE_BITS  = sfvt_pkg::ValueBitsDefault
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // command, state_flags, write_value
    input  logic [((2 + FLAG_BITS + VALUE_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // status, read_value, entry_count
    output logic [47:0] m_axis_tdata
);
    import sfvt_pkg::*;

    logic [31:0]           default_reg;
    logic                  q_valid, q_pop;
    cmd_t                  q_cmd;
    logic [FLAG_BITS-1:0]  q_key;
    logic [VALUE_BITS-1:0] q_val;
    logic [2:0]            st;
    logic [31:0]           rv;
    logic [4:0]            cnt;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            default_reg <= '0;
        end
        else if (cfg_we)
        begin
            default_reg <= cfg_wdata;
        end
    end

    sfvt_front #(.FLAG_BITS(FLAG_BITS), .VALUE_BITS(VALUE_BITS)) u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
        .in_cmd(s_axis_tdata[1:0]),
        .in_key(s_axis_tdata[2 +: FLAG_BITS]),
        .in_val(s_axis_tdata[2 + FLAG_BITS +: VALUE_BITS]),
        .q_valid(q_valid), .q_pop(q_pop), .q_cmd(q_cmd), .q_key(q_key), .q_val(q_val));

    sfvt_engine #(.TABLE_DEPTH(TABLE_DEPTH), .FLAG_BITS(FLAG_BITS),
                  .VALUE_BITS(VALUE_BITS)) u_engine (
        .clk(clk), .rst_n(rst_n), .miss_word(default_reg),
        .q_valid(q_valid), .q_pop(q_pop), .q_cmd(q_cmd), .q_key(q_key), .q_val(q_val),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
        .out_status(st), .out_value(rv), .out_count(cnt));

    assign m_axis_tdata = {8'd0, cnt, rv, st};

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[2:0] != 3'd7))
        else $error("illegal status");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[39:35] <= 5'(TABLE_DEPTH)))
        else $error("entry count beyond depth");
    a_nonget_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tdata[2:0] == ST_STORED || m_axis_tdata[2:0] == ST_REMOVED))
        |-> (m_axis_tdata[34:3] == 32'd0))
        else $error("value on non-get result");
endmodule

// ===== dv/tb_state_flag_value_table_unit.sv =====
// Self-checking testbench for the sorted state flag value table.
`timescale 1ns / 1ps

module tb_state_flag_value_table_unit;
    import sfvt_pkg::*;

    localparam int Depth = 16;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [31:0] cfg_wdata;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    // command[1:0], state_flags[9:2], write_value[41:10], zero fill
    logic [47:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    // status[2:0], read_value[34:3], entry_count[39:35], zero fill
    logic [47:0] m_axis_tdata;

    // Ordered so that status lands in the lowest bits, as on the bus.
    typedef struct packed {
        logic [4:0]  entry_count;
        logic [31:0] read_value;
        logic [2:0]  status;
    } answer_t;

    // Shadow of the table contents.
    logic [7:0]  tbl_keys [Depth];
    logic [31:0] tbl_vals [Depth];
    int          tbl_used;
    logic [31:0] tbl_default;

    answer_t pending_answers[$];
    int      mismatches;
    int      answers_seen;
    bit      burst_on;
    int      burst_left;
    bit      stall_mode;

    state_flag_value_table_unit dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #50ms;
        $display("== FAIL ==");
        $finish;
    end

    function automatic answer_t predict_lookup(cmd_t cmd, logic [7:0] key, logic [31:0] wval);
        answer_t a;
        int pos;
        bit hit;
        int j;
        a.status = ST_ABSENT;
        a.read_value = '0;
        pos = 0;
        while (pos < tbl_used && tbl_keys[pos] < key)
            pos++;
        hit = (pos < tbl_used) && (tbl_keys[pos] == key);
        case (cmd)
            CMD_SET:
            begin
                if (hit)
                begin
                    tbl_vals[pos] = wval;
                    a.status = ST_STORED;
                end
                else if (tbl_used >= Depth)
                    a.status = ST_FULL;
                else
                begin
                    for (int i = tbl_used; i > pos; i--)
                    begin
                        tbl_keys[i] = tbl_keys[i-1];
                        tbl_vals[i] = tbl_vals[i-1];
                    end
                    tbl_keys[pos] = key;
                    tbl_vals[pos] = wval;
                    tbl_used++;
                    a.status = ST_STORED;
                end
            end
            CMD_UNSET:
            begin
                if (hit)
                begin
                    for (int i = pos; i + 1 < tbl_used; i++)
                    begin
                        tbl_keys[i] = tbl_keys[i+1];
                        tbl_vals[i] = tbl_vals[i+1];
                    end
                    tbl_used--;
                    a.status = ST_REMOVED;
                end
            end
            CMD_GET:
            begin
                if (hit)
                begin
                    a.read_value = tbl_vals[pos];
                    a.status = ST_EXACT;
                end
                else
                begin
                    j = (pos < tbl_used) ? pos + 1 : tbl_used;
                    a.status = ST_DEFAULT;
                    a.read_value = tbl_default;
                    while (j > 0)
                    begin
                        j--;
                        if (tbl_keys[j] == 0 ||
                            ((tbl_keys[j] & key) != 0 && (tbl_keys[j] & ~key) == 0))
                        begin
                            a.read_value = tbl_vals[j];
                            a.status = ST_FALLBACK;
                            break;
                        end
                    end
                end
            end
            default: ;
        endcase
        a.entry_count = tbl_used[4:0];
        return a;
    endfunction

    // Sends one beat, with bursts and gaps on the sender side.
    task automatic send_command(cmd_t cmd, logic [7:0] key, logic [31:0] wval);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 6);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'd0, wval, key, cmd};
        // Ready is settled at the falling edge, so the beat is taken at the next rise.
        @(negedge clk);
        while (!s_axis_tready)
            @(negedge clk);
        @(posedge clk);
        pending_answers.push_back(predict_lookup(cmd, key, wval));
    endtask

    task automatic drain_and_idle();
        int guard;
        guard = 0;
        s_axis_tvalid <= 1'b0;
        while (pending_answers.size() != 0 && guard < 200000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (100) @(posedge clk);
    endtask

    task automatic write_default(logic [31:0] v);
        drain_and_idle();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        tbl_default = v;
    endtask

    always @(posedge clk)
    begin
        answer_t got;
        answer_t exp_a;
        if (m_axis_tvalid && m_axis_tready)
        begin
            got = answer_t'(m_axis_tdata[39:0]);
            answers_seen++;
            if (pending_answers.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected beat %h", got);
            end
            else
            begin
                exp_a = pending_answers.pop_front();
                if (got !== exp_a)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected st=%0d val=%h cnt=%0d, got st=%0d val=%h cnt=%0d",
                                 exp_a.status, exp_a.read_value, exp_a.entry_count,
                                 got.status, got.read_value, got.entry_count);
                end
            end
        end
    end

    // Receiver stalls, switching between free running and random backpressure.
    always @(posedge clk)
    begin
        if ($urandom_range(0, 199) == 0)
            stall_mode <= ~stall_mode;
        m_axis_tready <= stall_mode ? ($urandom_range(0, 2) == 0) : 1'b1;
    end

    task automatic test_directed();
        send_command(CMD_GET, 8'h00, 32'h0);
        send_command(CMD_UNSET, 8'h55, 32'h0);
        send_command(CMD_NONE, 8'hFF, 32'hFFFFFFFF);
        send_command(CMD_SET, 8'hFF, 32'hFFFFFFFF);
        send_command(CMD_SET, 8'h03, 32'h12345678);
        send_command(CMD_GET, 8'h07, 32'h0);
        send_command(CMD_GET, 8'h04, 32'h0);
        send_command(CMD_SET, 8'h00, 32'hA5A5A5A5);
        send_command(CMD_GET, 8'h04, 32'h0);
        send_command(CMD_SET, 8'h03, 32'h00000000);
        send_command(CMD_GET, 8'h03, 32'h0);
        send_command(CMD_UNSET, 8'h00, 32'h0);
        send_command(CMD_UNSET, 8'hFF, 32'h0);
        for (int i = 1; i <= Depth + 1; i++)
            send_command(CMD_SET, 8'(i * 15), $urandom);
        send_command(CMD_SET, 8'd15, 32'hDEADBEEF);
        send_command(CMD_GET, 8'hFF, 32'h0);
    endtask

    task automatic clear_table();
        for (int k = 0; k < 256; k++)
            send_command(CMD_UNSET, 8'(k), $urandom);
    endtask

    task automatic test_random(int n, int key_bits);
        logic [7:0] key;
        cmd_t cmd;
        int r;
        for (int i = 0; i < n; i++)
        begin
            key = 8'($urandom) & 8'((1 << key_bits) - 1);
            if ($urandom_range(0, 3) == 0)
                key = 8'($urandom);
            r = $urandom_range(0, 99);
            cmd = (r < 40) ? CMD_SET : (r < 60) ? CMD_UNSET : (r < 97) ? CMD_GET : CMD_NONE;
            send_command(cmd, key, $urandom);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        stall_mode = 1'b0;
        tbl_used = 0;
        tbl_default = '0;
        mismatches = 0;
        answers_seen = 0;
        burst_left = 0;
        for (int i = 0; i < Depth; i++)
        begin
            tbl_keys[i] = '0;
            tbl_vals[i] = '0;
        end
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        write_default(32'hFFFFFFFF);
        send_command(CMD_GET, 8'h00, 32'h0);
        clear_table();
        send_command(CMD_GET, 8'h81, 32'h0);
        write_default($urandom);
        test_random(400, 4);
        write_default(32'h00000000);
        test_random(400, 8);
        write_default($urandom);
        test_random(400, 3);

        drain_and_idle();
        if (mismatches == 0 && pending_answers.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule

// ===== filelist.f =====
hw/rtl/sfvt_pkg.sv
hw/rtl/sfvt_ram.sv
hw/rtl/sfvt_front.sv
hw/rtl/sfvt_engine.sv
hw/rtl/state_flag_value_table_unit.sv
dv/tb_state_flag_value_table_unit.sv
